@@ design/cbaa_pkg.sv @@
// Shared constants, codes and control types of the compacting bitmap arena allocator.
`default_nettype none
package cbaa_pkg;

  localparam int NUM_SLOTS   = 64;
  localparam int ID_W        = $clog2(NUM_SLOTS);
  localparam int ARENA_WORDS = 4096;
  localparam int ADDR_W      = $clog2(ARENA_WORDS);
  localparam int PTR_W       = ADDR_W + 1;
  localparam int SIZE_W      = ADDR_W + 1;
  localparam int SLOT_W      = ADDR_W + SIZE_W;
  localparam int MAX_LINE    = 4094;
  localparam int LINE_W      = 12;
  localparam int NW_W        = LINE_W + 32;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_DEPTH  = 3'd1,
    ST_NO_SLOT    = 3'd2,
    ST_NO_STORE   = 3'd3,
    ST_BAD_ID     = 3'd4,
    ST_BAD_OFFSET = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_SET_ERR, OP_ARITH, OP_MUL_NW, OP_MUL_Z,
    OP_C_INIT, OP_C_RDSZ, OP_C_RDOWN, OP_C_OWNER, OP_C_RD, OP_C_WR, OP_C_END,
    OP_HDR0, OP_HDR1, OP_ZERO, OP_COMMIT, OP_FREE, OP_READ, OP_WRITE,
    OP_RDLATCH, OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL1, S_MUL2, S_FIT, S_C_TEST, S_C_SZ, S_C_OWN,
    S_C_RD, S_C_WR, S_HDR0, S_HDR1, S_ZERO, S_COMMIT, S_RDW, S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    status_t err;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic fh_zero;
    logic id_bad;
    logic off_bad;
    logic alloc_bad;
    logic fits;
    logic compacted;
    logic c_more;
    logic c_break;
    logic c_move;
    logic c_last;
    logic zero_done;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ design/cbaa_ifs.sv @@
// Valid/ready channel interfaces for command and result words.
`default_nettype none
interface cbaa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic               pixel_depth;
  logic signed [31:0] rect_min_x;
  logic signed [31:0] rect_min_y;
  logic signed [31:0] rect_max_x;
  logic signed [31:0] rect_max_y;
  logic [5:0]         slot_id;
  logic [11:0]        word_offset;
  logic [31:0]        write_data;

  modport source (output valid, cmd, pixel_depth, rect_min_x, rect_min_y, rect_max_x,
                  rect_max_y, slot_id, word_offset, write_data, input ready);
  modport sink (input valid, cmd, pixel_depth, rect_min_x, rect_min_y, rect_max_x,
                rect_max_y, slot_id, word_offset, write_data, output ready);
endinterface

interface cbaa_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [5:0]         new_id;
  logic [11:0]        base_addr;
  logic [11:0]        line_words;
  logic signed [31:0] zero_offset;
  logic [31:0]        read_data;

  modport source (output valid, status, new_id, base_addr, line_words, zero_offset,
                  read_data, input ready);
  modport sink (input valid, status, new_id, base_addr, line_words, zero_offset,
                read_data, output ready);
endinterface
`default_nettype wire

@@ design/cbaa_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module cbaa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

@@ design/cbaa_ctrl.sv @@
// Controller state machine: sequences allocate, compaction, free and word access.
`default_nettype none
module cbaa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  cbaa_pkg::dp_stat_t  stat,
  output cbaa_pkg::ctrl_cmd_t ctl
);
  import cbaa_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_ALLOC: state_nxt = stat.fh_zero ? S_DONE : S_MUL1;
          CMD_FREE:  state_nxt = S_DONE;
          CMD_READ:  state_nxt = (stat.id_bad || stat.off_bad) ? S_DONE : S_RDW;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_MUL1:   state_nxt = stat.alloc_bad ? S_DONE : S_MUL2;
      S_MUL2:   state_nxt = S_FIT;
      S_FIT: begin
        if (stat.fits) begin
          state_nxt = S_HDR0;
        end else if (!stat.compacted) begin
          state_nxt = S_C_TEST;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_C_TEST: state_nxt = stat.c_more ? S_C_SZ : S_FIT;
      S_C_SZ:   state_nxt = S_C_OWN;
      S_C_OWN: begin
        if (stat.c_break) begin
          state_nxt = S_FIT;
        end else if (stat.c_move) begin
          state_nxt = S_C_RD;
        end else begin
          state_nxt = S_C_TEST;
        end
      end
      S_C_RD:   state_nxt = S_C_WR;
      S_C_WR:   state_nxt = stat.c_last ? S_C_TEST : S_C_RD;
      S_HDR0:   state_nxt = S_HDR1;
      S_HDR1:   state_nxt = S_ZERO;
      S_ZERO:   if (stat.zero_done) state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_DONE;
      S_RDW:    state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.op   = OP_NONE;
    ctl.err  = ST_OK;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctl.op = OP_LATCH;
      end
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_ALLOC: begin
            if (stat.fh_zero) begin
              ctl.op  = OP_SET_ERR;
              ctl.err = ST_NO_SLOT;
            end else begin
              ctl.op = OP_ARITH;
            end
          end
          default: begin
            if (stat.id_bad) begin
              ctl.op  = OP_SET_ERR;
              ctl.err = ST_BAD_ID;
            end else if (stat.cmd == CMD_FREE) begin
              ctl.op = OP_FREE;
            end else if (stat.off_bad) begin
              ctl.op  = OP_SET_ERR;
              ctl.err = ST_BAD_OFFSET;
            end else if (stat.cmd == CMD_READ) begin
              ctl.op = OP_READ;
            end else begin
              ctl.op = OP_WRITE;
            end
          end
        endcase
      end
      S_MUL1: begin
        if (stat.alloc_bad) begin
          ctl.op  = OP_SET_ERR;
          ctl.err = ST_NO_STORE;
        end else begin
          ctl.op = OP_MUL_NW;
        end
      end
      S_MUL2: ctl.op = OP_MUL_Z;
      S_FIT: begin
        if (!stat.fits && !stat.compacted) begin
          ctl.op = OP_C_INIT;
        end else if (!stat.fits) begin
          ctl.op  = OP_SET_ERR;
          ctl.err = ST_NO_STORE;
        end
      end
      S_C_TEST: ctl.op = stat.c_more ? OP_C_RDSZ : OP_C_END;
      S_C_SZ:   ctl.op = OP_C_RDOWN;
      S_C_OWN:  ctl.op = stat.c_break ? OP_C_END : OP_C_OWNER;
      S_C_RD:   ctl.op = OP_C_RD;
      S_C_WR:   ctl.op = OP_C_WR;
      S_HDR0:   ctl.op = OP_HDR0;
      S_HDR1:   ctl.op = OP_HDR1;
      S_ZERO:   if (!stat.zero_done) ctl.op = OP_ZERO;
      S_COMMIT: ctl.op = OP_COMMIT;
      S_RDW:    ctl.op = OP_RDLATCH;
      S_DONE:   if (out_free) ctl.op = OP_OUT;
      default:  ctl.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (state_r == S_DONE && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

@@ design/cbaa_dp.sv @@
// Datapath: arena and slot tables, geometry arithmetic, compaction pointers, result registers.
`default_nettype none
module cbaa_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cbaa_pkg::ctrl_cmd_t          ctl,
  output cbaa_pkg::dp_stat_t           stat,
  input  logic [1:0]                   in_cmd,
  input  logic                         in_pixel_depth,
  input  logic signed [31:0]           in_rect_min_x,
  input  logic signed [31:0]           in_rect_min_y,
  input  logic signed [31:0]           in_rect_max_x,
  input  logic signed [31:0]           in_rect_max_y,
  input  logic [cbaa_pkg::ID_W-1:0]    in_slot_id,
  input  logic [cbaa_pkg::ADDR_W-1:0]  in_word_offset,
  input  logic [31:0]                  in_write_data,
  output logic [2:0]                   out_status,
  output logic [cbaa_pkg::ID_W-1:0]    out_new_id,
  output logic [cbaa_pkg::ADDR_W-1:0]  out_base_addr,
  output logic [cbaa_pkg::LINE_W-1:0]  out_line_words,
  output logic signed [31:0]           out_zero_offset,
  output logic [31:0]                  out_read_data
);
  import cbaa_pkg::*;

  // control state
  logic [PTR_W-1:0]     fill_r, fill_nxt;
  logic [ID_W-1:0]      fh_r, fh_nxt;
  logic [NUM_SLOTS-1:0] live_r, live_nxt;
  logic [NUM_SLOTS-1:0] fnv_r, fnv_nxt;
  logic                 compacted_r, compacted_nxt;

  // latched command
  cmd_t               cmd_r, cmd_nxt;
  logic               dep_r, dep_nxt;
  logic signed [31:0] minx_r, minx_nxt, miny_r, miny_nxt, maxx_r, maxx_nxt, maxy_r, maxy_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [ADDR_W-1:0]  off_r, off_nxt;
  logic [31:0]        wd_r, wd_nxt;

  // arithmetic
  logic signed [33:0] fl_r, fl_nxt, l_r, l_nxt;
  logic signed [32:0] dy_r, dy_nxt;
  logic [NW_W-1:0]    nw_r, nw_nxt;
  logic [31:0]        z_r, z_nxt;
  logic [ID_W-1:0]    fnx_r, fnx_nxt;

  // compaction and zero fill
  logic [PTR_W-1:0] src_r, src_nxt, dst_r, dst_nxt, k_r, k_nxt, len_r, len_nxt;
  logic [31:0]      size_r, size_nxt;
  logic [PTR_W-1:0] zp_r, zp_nxt, zcnt_r, zcnt_nxt;

  // result working and output registers
  status_t             rst_r, rst_nxt;
  logic [ID_W-1:0]     rid_r, rid_nxt;
  logic [ADDR_W-1:0]   rbase_r, rbase_nxt;
  logic [LINE_W-1:0]   rlw_r, rlw_nxt;
  logic [31:0]         rzo_r, rzo_nxt, rrd_r, rrd_nxt;
  status_t             ost_r, ost_nxt;
  logic [ID_W-1:0]     oid_r, oid_nxt;
  logic [ADDR_W-1:0]   obase_r, obase_nxt;
  logic [LINE_W-1:0]   olw_r, olw_nxt;
  logic [31:0]         ozo_r, ozo_nxt, ord_r, ord_nxt;

  // memory ports
  logic              a_we;
  logic [ADDR_W-1:0] a_waddr, a_raddr;
  logic [31:0]       a_wdata, a_rdata;
  logic              s_we;
  logic [ID_W-1:0]   s_waddr, s_raddr;
  logic [SLOT_W-1:0] s_wdata, s_rdata;
  logic              f_we;
  logic [ID_W-1:0]   f_waddr;
  logic [ID_W-1:0]   f_wdata, f_rdata;

  // combinational helpers
  logic [ADDR_W-1:0]  s_base;
  logic [SIZE_W-1:0]  s_size;
  logic [PTR_W-1:0]   sb_off, src_p1, src_k, dst_k, blk_base, dst_p2;
  logic signed [33:0] minx34, maxx34, ppm1, ce;
  logic [2:0]         sh;
  logic [33:0]        len34;
  logic               own_ok;
  logic [ID_W-1:0]    fh_inc;

  assign s_base = s_rdata[SLOT_W-1:SIZE_W];
  assign s_size = s_rdata[SIZE_W-1:0];
  assign sb_off = {1'b0, s_base} + {1'b0, off_r};
  assign src_p1 = src_r + PTR_W'(1);
  assign src_k  = src_r + k_r;
  assign dst_k  = dst_r + k_r;
  assign dst_p2 = dst_r + PTR_W'(2);
  assign blk_base = fill_r + PTR_W'(2);
  assign len34  = {2'b0, size_r} + 34'd2;
  assign own_ok = (a_rdata != 32'd0) && (a_rdata[31:ID_W] == '0);
  assign fh_inc = fh_r + ID_W'(1);

  // floor of min_x and ceiling of max_x in words
  assign sh     = dep_r ? 3'd4 : 3'd5;
  assign ppm1   = dep_r ? 34'sd15 : 34'sd31;
  assign minx34 = {{2{minx_r[31]}}, minx_r};
  assign maxx34 = {{2{maxx_r[31]}}, maxx_r};
  assign ce     = (maxx34 + ppm1) >>> sh;

  always_comb begin
    stat.cmd       = cmd_r;
    stat.fh_zero   = (fh_r == '0);
    stat.id_bad    = !live_r[id_r] || (cmd_r == CMD_FREE && id_r == '0);
    stat.off_bad   = ({1'b0, off_r} >= s_size) || sb_off[PTR_W-1];
    stat.alloc_bad = (l_r < 34'sd0) || (dy_r < 33'sd0) || (l_r > 34'(MAX_LINE));
    stat.fits      = ((46'(fill_r) + 46'd2 + 46'(nw_r)) <= 46'(ARENA_WORDS));
    stat.compacted = compacted_r;
    stat.c_more    = (src_r < fill_r) && (src_p1 < PTR_W'(ARENA_WORDS));
    stat.c_break   = (34'(src_r) + len34) > 34'(ARENA_WORDS);
    stat.c_move    = own_ok && (dst_r != src_r);
    stat.c_last    = (k_r == len_r - PTR_W'(1));
    stat.zero_done = (zcnt_r == nw_r[PTR_W-1:0]);
  end

  always_comb begin
    fill_nxt = fill_r; fh_nxt = fh_r; live_nxt = live_r; fnv_nxt = fnv_r;
    compacted_nxt = compacted_r;
    cmd_nxt = cmd_r; dep_nxt = dep_r; minx_nxt = minx_r; miny_nxt = miny_r;
    maxx_nxt = maxx_r; maxy_nxt = maxy_r; id_nxt = id_r; off_nxt = off_r; wd_nxt = wd_r;
    fl_nxt = fl_r; l_nxt = l_r; dy_nxt = dy_r; nw_nxt = nw_r; z_nxt = z_r; fnx_nxt = fnx_r;
    src_nxt = src_r; dst_nxt = dst_r; k_nxt = k_r; len_nxt = len_r; size_nxt = size_r;
    zp_nxt = zp_r; zcnt_nxt = zcnt_r;
    rst_nxt = rst_r; rid_nxt = rid_r; rbase_nxt = rbase_r; rlw_nxt = rlw_r;
    rzo_nxt = rzo_r; rrd_nxt = rrd_r;
    ost_nxt = ost_r; oid_nxt = oid_r; obase_nxt = obase_r; olw_nxt = olw_r;
    ozo_nxt = ozo_r; ord_nxt = ord_r;
    a_we = 1'b0; a_waddr = zp_r[ADDR_W-1:0]; a_wdata = 32'd0; a_raddr = src_r[ADDR_W-1:0];
    s_we = 1'b0; s_waddr = fh_r; s_wdata = {blk_base[ADDR_W-1:0], nw_r[SIZE_W-1:0]};
    s_raddr = id_r;
    f_we = 1'b0; f_waddr = id_r; f_wdata = fh_r;

    unique case (ctl.op)
      OP_LATCH: begin
        cmd_nxt  = cmd_t'(in_cmd);
        dep_nxt  = in_pixel_depth;
        minx_nxt = in_rect_min_x; miny_nxt = in_rect_min_y;
        maxx_nxt = in_rect_max_x; maxy_nxt = in_rect_max_y;
        id_nxt   = in_slot_id; off_nxt = in_word_offset; wd_nxt = in_write_data;
        s_raddr  = in_slot_id;
        compacted_nxt = 1'b0;
        rst_nxt = ST_OK; rid_nxt = '0; rbase_nxt = '0; rlw_nxt = '0;
        rzo_nxt = '0; rrd_nxt = '0;
      end
      OP_SET_ERR: rst_nxt = ctl.err;
      OP_ARITH: begin
        fl_nxt  = minx34 >>> sh;
        l_nxt   = ce - (minx34 >>> sh);
        dy_nxt  = {maxy_r[31], maxy_r} - {miny_r[31], miny_r};
        fnx_nxt = fnv_r[fh_r] ? f_rdata : fh_inc;
      end
      OP_MUL_NW: nw_nxt = l_r[LINE_W-1:0] * dy_r[31:0];
      OP_MUL_Z:  z_nxt  = 32'(l_r[LINE_W-1:0] * $unsigned(miny_r)) + fl_r[31:0];
      OP_C_INIT: begin
        src_nxt = '0;
        dst_nxt = '0;
      end
      OP_C_RDSZ: a_raddr = src_r[ADDR_W-1:0];
      OP_C_RDOWN: begin
        size_nxt = a_rdata;
        a_raddr  = src_p1[ADDR_W-1:0];
      end
      OP_C_OWNER: begin
        // move the block and rebase its owner, keep it in place, or skip a freed one
        if (own_ok && dst_r != src_r) begin
          s_we    = 1'b1;
          s_waddr = a_rdata[ID_W-1:0];
          s_wdata = {dst_p2[ADDR_W-1:0], size_r[SIZE_W-1:0]};
          len_nxt = len34[PTR_W-1:0];
          k_nxt   = '0;
        end else if (own_ok) begin
          dst_nxt = dst_r + len34[PTR_W-1:0];
          src_nxt = src_r + len34[PTR_W-1:0];
        end else begin
          src_nxt = src_r + len34[PTR_W-1:0];
        end
      end
      OP_C_RD: a_raddr = src_k[ADDR_W-1:0];
      OP_C_WR: begin
        a_we    = 1'b1;
        a_waddr = dst_k[ADDR_W-1:0];
        a_wdata = a_rdata;
        k_nxt   = k_r + PTR_W'(1);
        if (k_r == len_r - PTR_W'(1)) begin
          dst_nxt = dst_r + len_r;
          src_nxt = src_r + len_r;
        end
      end
      OP_C_END: begin
        fill_nxt      = dst_r;
        compacted_nxt = 1'b1;
      end
      OP_HDR0: begin
        a_we    = 1'b1;
        a_waddr = fill_r[ADDR_W-1:0];
        a_wdata = nw_r[31:0];
      end
      OP_HDR1: begin
        a_we     = 1'b1;
        a_waddr  = fill_r[ADDR_W-1:0] + ADDR_W'(1);
        a_wdata  = 32'(fh_r);
        zp_nxt   = blk_base;
        zcnt_nxt = '0;
      end
      OP_ZERO: begin
        a_we     = 1'b1;
        a_waddr  = zp_r[ADDR_W-1:0];
        a_wdata  = 32'd0;
        zp_nxt   = zp_r + PTR_W'(1);
        zcnt_nxt = zcnt_r + PTR_W'(1);
      end
      OP_COMMIT: begin
        s_we      = 1'b1;
        s_waddr   = fh_r;
        s_wdata   = {blk_base[ADDR_W-1:0], nw_r[SIZE_W-1:0]};
        live_nxt[fh_r] = 1'b1;
        fh_nxt    = fnx_r;
        fill_nxt  = blk_base + nw_r[PTR_W-1:0];
        rid_nxt   = fh_r;
        rbase_nxt = blk_base[ADDR_W-1:0];
        rlw_nxt   = l_r[LINE_W-1:0];
        rzo_nxt   = 32'd0 - z_r;
      end
      OP_FREE: begin
        a_we    = 1'b1;
        a_waddr = s_base - ADDR_W'(1);
        a_wdata = 32'd0;
        live_nxt[id_r] = 1'b0;
        f_we    = 1'b1;
        f_waddr = id_r;
        f_wdata = fh_r;
        fnv_nxt[id_r] = 1'b1;
        fh_nxt  = id_r;
      end
      OP_READ: a_raddr = sb_off[ADDR_W-1:0];
      OP_WRITE: begin
        a_we    = 1'b1;
        a_waddr = sb_off[ADDR_W-1:0];
        a_wdata = wd_r;
      end
      OP_RDLATCH: rrd_nxt = a_rdata;
      OP_OUT: begin
        ost_nxt = rst_r; oid_nxt = rid_r; obase_nxt = rbase_r; olw_nxt = rlw_r;
        ozo_nxt = rzo_r; ord_nxt = rrd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      fh_r        <= ID_W'(1);
      live_r      <= '0;
      fnv_r       <= '0;
      compacted_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      fh_r        <= fh_nxt;
      live_r      <= live_nxt;
      fnv_r       <= fnv_nxt;
      compacted_r <= compacted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; dep_r <= dep_nxt; minx_r <= minx_nxt; miny_r <= miny_nxt;
    maxx_r <= maxx_nxt; maxy_r <= maxy_nxt; id_r <= id_nxt; off_r <= off_nxt; wd_r <= wd_nxt;
    fl_r <= fl_nxt; l_r <= l_nxt; dy_r <= dy_nxt; nw_r <= nw_nxt; z_r <= z_nxt;
    fnx_r <= fnx_nxt;
    src_r <= src_nxt; dst_r <= dst_nxt; k_r <= k_nxt; len_r <= len_nxt; size_r <= size_nxt;
    zp_r <= zp_nxt; zcnt_r <= zcnt_nxt;
    rst_r <= rst_nxt; rid_r <= rid_nxt; rbase_r <= rbase_nxt; rlw_r <= rlw_nxt;
    rzo_r <= rzo_nxt; rrd_r <= rrd_nxt;
    ost_r <= ost_nxt; oid_r <= oid_nxt; obase_r <= obase_nxt; olw_r <= olw_nxt;
    ozo_r <= ozo_nxt; ord_r <= ord_nxt;
  end

  cbaa_ram #(.WIDTH(32), .DEPTH(ARENA_WORDS)) u_arena (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr), .rdata(a_rdata)
  );

  cbaa_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );

  cbaa_ram #(.WIDTH(ID_W), .DEPTH(NUM_SLOTS)) u_fnext (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(fh_r), .rdata(f_rdata)
  );

  assign out_status      = ost_r;
  assign out_new_id      = oid_r;
  assign out_base_addr   = obase_r;
  assign out_line_words  = olw_r;
  assign out_zero_offset = ozo_r;
  assign out_read_data   = ord_r;
endmodule
`default_nettype wire

@@ design/compacting_bitmap_arena_allocator.sv @@
// Top level of the compacting bitmap arena allocator.
// A 4096-word arena holds bitmap blocks, each a two-word header (size, owner
// slot) followed by its data words, with up to 63 live slots taken from a
// LIFO free list. One command word is worked on at a time; ready is high only
// while the controller idles, and the result word sits in an output register
// so the next command is taken while a result still waits. An allocate that
// fits zeroes its block one word a cycle through the single arena write port.
// When the block does not fit, the arena is compacted first: each block header
// visited is read (size, then owner), and every block that moves is copied
// word by word (read, then write through the one arena port). No clearing
// pass follows reset; the controller comes out of reset idle and ready.
`default_nettype none
module compacting_bitmap_arena_allocator (
  input logic        clk,
  input logic        rst_n,
  cbaa_in_if.sink    in_chan,
  cbaa_out_if.source out_chan
);
  import cbaa_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  // sequence the work
  cbaa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // hold arena, slot tables and result word
  cbaa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_cmd          (in_chan.cmd),
    .in_pixel_depth  (in_chan.pixel_depth),
    .in_rect_min_x   (in_chan.rect_min_x),
    .in_rect_min_y   (in_chan.rect_min_y),
    .in_rect_max_x   (in_chan.rect_max_x),
    .in_rect_max_y   (in_chan.rect_max_y),
    .in_slot_id      (in_chan.slot_id),
    .in_word_offset  (in_chan.word_offset),
    .in_write_data   (in_chan.write_data),
    .out_status      (out_chan.status),
    .out_new_id      (out_chan.new_id),
    .out_base_addr   (out_chan.base_addr),
    .out_line_words  (out_chan.line_words),
    .out_zero_offset (out_chan.zero_offset),
    .out_read_data   (out_chan.read_data)
  );
endmodule
`default_nettype wire

@@ design/cbaa_chk.sv @@
// Port-level checker of the allocator result channel, bound to the top level.
`default_nettype none
module cbaa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [5:0]  out_new_id,
  input logic [11:0] out_base_addr,
  input logic [11:0] out_line_words,
  input logic [31:0] out_zero_offset,
  input logic [31:0] out_read_data
);
  import cbaa_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_read_data)
      && $stable(out_new_id))
    else $error("result word changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_new_id == '0 && out_base_addr == '0
      && out_line_words == '0 && out_zero_offset == '0 && out_read_data == '0)
    else $error("error result carries nonzero fields");

  a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_id != '0 |-> out_status == ST_OK && out_read_data == '0
      && out_line_words <= 12'(MAX_LINE))
    else $error("allocate result inconsistent");
endmodule

bind compacting_bitmap_arena_allocator cbaa_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_new_id      (out_chan.new_id),
  .out_base_addr   (out_chan.base_addr),
  .out_line_words  (out_chan.line_words),
  .out_zero_offset (out_chan.zero_offset),
  .out_read_data   (out_chan.read_data)
);
`default_nettype wire

@@ tb/cbaa_checker.sv @@
// Checker for the arena allocator: mirrors its state, predicts each result word, compares.
`timescale 1ns / 1ps
module cbaa_checker
  import cbaa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  cbaa_in_if    mon_in,
  cbaa_out_if   mon_out,
  output int    err_count,
  output int    pending
);

  typedef struct packed {
    status_t      status;
    logic [5:0]   new_id;
    logic [11:0]  base_addr;
    logic [11:0]  line_words;
    logic [31:0]  zero_offset;
    logic [31:0]  read_data;
  } result_word_t;

  logic [31:0] arena_mem [0:ARENA_WORDS-1];
  longint      fill_ptr;
  bit          live    [0:NUM_SLOTS-1];
  longint      blk_base[0:NUM_SLOTS-1];
  longint      blk_size[0:NUM_SLOTS-1];
  int          next_free[0:NUM_SLOTS-1];
  int          free_head;

  result_word_t awaited_words[$];

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if (a % d < 0) q--;
    return q;
  endfunction

  // Slide live blocks down over freed ones and rebase their slots.
  function automatic void compact_arena();
    longint dst, src, len;
    logic [31:0] owner;
    dst = 0;
    src = 0;
    while (src < fill_ptr && src + 1 < ARENA_WORDS) begin
      len = 2 + longint'(arena_mem[src]);
      owner = arena_mem[src+1];
      if (src + len > ARENA_WORDS) break;
      if (owner != 0 && owner < NUM_SLOTS) begin
        if (dst != src) begin
          for (longint k = 0; k < len; k++) arena_mem[dst+k] = arena_mem[src+k];
          blk_base[owner] = dst + 2;
        end
        dst += len;
      end
      src += len;
    end
    fill_ptr = dst;
  endfunction

  function automatic result_word_t predict_arena_result(
    cmd_t cmd, logic depth, logic signed [31:0] mnx, logic signed [31:0] mny,
    logic signed [31:0] mxx, logic signed [31:0] mxy,
    logic [5:0] id, logic [11:0] off, logic [31:0] wdata);
    result_word_t r;
    longint ppw, fl, lw, dy, nw;
    int s;
    logic [31:0] z;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_ALLOC: begin
        if (free_head == 0) begin
          r.status = ST_NO_SLOT;
        end else begin
          ppw = longint'(1) << (5 - depth);
          fl = floor_div(longint'(mnx), ppw);
          lw = -floor_div(-longint'(mxx), ppw) - fl;
          dy = longint'(mxy) - longint'(mny);
          if (lw < 0 || dy < 0 || lw > MAX_LINE) begin
            r.status = ST_NO_STORE;
          end else begin
            nw = lw * dy;
            if (fill_ptr + 2 + nw > ARENA_WORDS) compact_arena();
            if (fill_ptr + 2 + nw > ARENA_WORDS) begin
              r.status = ST_NO_STORE;
            end else begin
              s = free_head;
              free_head = next_free[s];
              arena_mem[fill_ptr]   = nw[31:0];
              arena_mem[fill_ptr+1] = s;
              for (longint k = 0; k < nw; k++) arena_mem[fill_ptr+2+k] = '0;
              live[s] = 1;
              blk_base[s] = fill_ptr + 2;
              blk_size[s] = nw;
              fill_ptr = fill_ptr + 2 + nw;
              z = lw[31:0] * mny + fl[31:0];
              r.new_id = 6'(s);
              r.base_addr = blk_base[s][11:0];
              r.line_words = lw[11:0];
              r.zero_offset = -z;
            end
          end
        end
      end
      CMD_FREE: begin
        if (id == 0 || !live[id]) begin
          r.status = ST_BAD_ID;
        end else begin
          if (blk_base[id] >= 1) arena_mem[blk_base[id]-1] = '0;
          live[id] = 0;
          next_free[id] = free_head;
          free_head = id;
        end
      end
      default: begin
        if (!live[id]) begin
          r.status = ST_BAD_ID;
        end else if (off >= blk_size[id] || blk_base[id] + off >= ARENA_WORDS) begin
          r.status = ST_BAD_OFFSET;
        end else if (cmd == CMD_READ) begin
          r.read_data = arena_mem[blk_base[id] + off];
        end else begin
          arena_mem[blk_base[id] + off] = wdata;
        end
      end
    endcase
    return r;
  endfunction

  assign pending = awaited_words.size();

  always @(posedge clk) begin
    result_word_t exp_w;
    if (!rst_n) begin
      for (int i = 0; i < ARENA_WORDS; i++) arena_mem[i] = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        live[i] = 0;
        blk_base[i] = 0;
        blk_size[i] = 0;
        next_free[i] = (i + 1 < NUM_SLOTS) ? i + 1 : 0;
      end
      fill_ptr = 0;
      free_head = 1;
      awaited_words.delete();
      err_count <= 0;
    end else begin
      if (mon_out.valid && mon_out.ready) begin
        if (awaited_words.size() == 0) begin
          $error("result word with nothing awaited");
          err_count <= err_count + 1;
        end else begin
          exp_w = awaited_words.pop_front();
          if (mon_out.status !== exp_w.status ||
              mon_out.new_id !== exp_w.new_id ||
              mon_out.base_addr !== exp_w.base_addr ||
              mon_out.line_words !== exp_w.line_words ||
              mon_out.zero_offset !== exp_w.zero_offset ||
              mon_out.read_data !== exp_w.read_data)
            err_count <= err_count + 1;
          if (mon_out.status !== exp_w.status)
            $error("status: expected %0d, got %0d", exp_w.status, mon_out.status);
          if (mon_out.new_id !== exp_w.new_id)
            $error("new_id: expected %0d, got %0d", exp_w.new_id, mon_out.new_id);
          if (mon_out.base_addr !== exp_w.base_addr)
            $error("base_addr: expected %0d, got %0d", exp_w.base_addr, mon_out.base_addr);
          if (mon_out.line_words !== exp_w.line_words)
            $error("line_words: expected %0d, got %0d", exp_w.line_words,
                   mon_out.line_words);
          if (mon_out.zero_offset !== exp_w.zero_offset)
            $error("zero_offset: expected %h, got %h", exp_w.zero_offset,
                   mon_out.zero_offset);
          if (mon_out.read_data !== exp_w.read_data)
            $error("read_data: expected %h, got %h", exp_w.read_data, mon_out.read_data);
        end
      end
      if (mon_in.valid && mon_in.ready)
        awaited_words.push_back(predict_arena_result(cmd_t'(mon_in.cmd),
          mon_in.pixel_depth, mon_in.rect_min_x, mon_in.rect_min_y, mon_in.rect_max_x,
          mon_in.rect_max_y, mon_in.slot_id, mon_in.word_offset, mon_in.write_data));
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top: clock, reset, command stimulus, result backpressure and verdict.
`timescale 1ns / 1ps
module tb;
  import cbaa_pkg::*;

  localparam int STALL_LIMIT = 60000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_WORDS  = 500;

  logic clk;
  logic rst_n;
  int   err_count;
  int   pending;
  int   send_idle;
  int   recv_idle;
  bit   hold_toggle;
  int   stall_cycles;

  cbaa_in_if  in_chan();
  cbaa_out_if out_chan();

  compacting_bitmap_arena_allocator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  cbaa_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .mon_in    (in_chan),
    .mon_out   (out_chan),
    .err_count (err_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Abort when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side: random backpressure; a toggle of hold_toggle asks for one long hold-off.
  initial begin
    bit hold_seen;
    hold_seen = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_chan.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offer one command word at a falling edge and return at the falling edge after it is taken.
  task automatic send_word(cmd_t cmd, logic depth, logic [31:0] mnx, logic [31:0] mny,
                           logic [31:0] mxx, logic [31:0] mxy, logic [5:0] id,
                           logic [11:0] off, logic [31:0] wdata);
    while ($urandom_range(99) < send_idle) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.cmd         <= cmd;
    in_chan.pixel_depth <= depth;
    in_chan.rect_min_x  <= mnx;
    in_chan.rect_min_y  <= mny;
    in_chan.rect_max_x  <= mxx;
    in_chan.rect_max_y  <= mxy;
    in_chan.slot_id     <= id;
    in_chan.word_offset <= off;
    in_chan.write_data  <= wdata;
    // ready comes from a register, so its value between edges is what the next edge sees
    while (!in_chan.ready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic alloc(logic depth, logic [31:0] mnx, logic [31:0] mny,
                       logic [31:0] mxx, logic [31:0] mxy);
    send_word(CMD_ALLOC, depth, mnx, mny, mxx, mxy, $urandom, $urandom, $urandom);
  endtask

  task automatic slot_op(cmd_t cmd, logic [5:0] id, logic [11:0] off, logic [31:0] wdata);
    send_word(cmd, $urandom, $urandom, $urandom, $urandom, $urandom, id, off, wdata);
  endtask

  // Mostly well-formed rectangles of a few dozen words; now and then a large or broken one.
  task automatic random_alloc();
    logic [31:0] mnx, mny;
    int pick;
    pick = $urandom_range(99);
    mnx = ($urandom_range(1)) ? $urandom : $urandom_range(200) - 100;
    mny = ($urandom_range(1)) ? $urandom : $urandom_range(40) - 20;
    if (pick < 4)
      alloc($urandom, mnx, mny, mnx + $urandom_range(40000, 1000), mny + $urandom_range(3));
    else if (pick < 7)
      alloc($urandom, mnx, mny, mnx - $urandom_range(500, 1), mny + 2);
    else if (pick < 9)
      alloc($urandom, mnx, mny, mnx + 64, mny + $urandom);
    else
      alloc($urandom, mnx, mny, mnx + $urandom_range(200), mny + $urandom_range(4));
  endtask

  // Low slot ids are the ones the free list hands out first, so aim there.
  function automatic logic [5:0] likely_slot();
    return ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(20, 1));
  endfunction

  task automatic random_words(int count);
    int n;
    int pick;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        // drain the free list with header-only blocks
        repeat (64) alloc($urandom, 0, 0, $urandom_range(100), 0);
        n += 64;
      end else if (pick < 6) begin
        for (int i = 1; i < NUM_SLOTS; i++) slot_op(CMD_FREE, i, 0, 0);
        n += NUM_SLOTS - 1;
      end else begin
        if (pick < 40) random_alloc();
        else if (pick < 65) slot_op(CMD_FREE, likely_slot(), 0, 0);
        else if (pick < 82) slot_op(CMD_READ, likely_slot(),
                                    ($urandom_range(9) == 0) ? $urandom : $urandom_range(40),
                                    0);
        else slot_op(CMD_WRITE, likely_slot(),
                     ($urandom_range(9) == 0) ? $urandom : $urandom_range(40), $urandom);
        n++;
      end
    end
  endtask

  initial begin
    in_chan.valid       = 1'b0;
    in_chan.cmd         = CMD_ALLOC;
    in_chan.pixel_depth = 1'b0;
    in_chan.rect_min_x  = '0;
    in_chan.rect_min_y  = '0;
    in_chan.rect_max_x  = '0;
    in_chan.rect_max_y  = '0;
    in_chan.slot_id     = '0;
    in_chan.word_offset = '0;
    in_chan.write_data  = '0;
    hold_toggle = 0;
    send_idle = 0;
    recv_idle = 0;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: edges of the rectangle math and the bad-id, bad-offset and no-store error paths
    alloc(0, 0, 0, 32, 2);
    alloc(1, 32'hFFFF_FFF1, 32'hFFFF_FFFE, 17, 1);
    alloc(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0040, 32'h8000_0001);
    alloc(1, 5, 3, 5, 3);
    slot_op(CMD_WRITE, 1, 0, 32'hFFFF_FFFF);
    slot_op(CMD_READ, 1, 0, 0);
    slot_op(CMD_READ, 1, 1, 0);
    slot_op(CMD_READ, 1, 2, 0);
    slot_op(CMD_WRITE, 1, 12'hFFF, 32'h1234_5678);
    slot_op(CMD_READ, 4, 0, 0);
    slot_op(CMD_READ, 6'h3F, 0, 0);
    slot_op(CMD_FREE, 0, 0, 0);
    slot_op(CMD_FREE, 6'h3F, 0, 0);
    alloc(0, 10, 0, 5, 4);
    alloc(0, 0, 5, 32, 4);
    alloc(0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 1);
    alloc(1, 0, 32'h8000_0000, 16, 32'h7FFF_FFFF);
    alloc(0, 0, 0, 32 * 4094, 0);
    slot_op(CMD_FREE, 2, 0, 0);
    slot_op(CMD_READ, 2, 0, 0);
    alloc(1, 0, 0, 16 * 1000, 4);
    slot_op(CMD_READ, 1, 0, 0);
    slot_op(CMD_READ, 2, 3999, 0);
    slot_op(CMD_WRITE, 2, 12'hFFF, 32'hA5A5_A5A5);
    slot_op(CMD_FREE, 2, 0, 0);

    send_idle = 30;
    recv_idle = 54;
    random_words(RAND_WORDS / 3);

    // let everything drain before going on
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    send_idle = 54;
    recv_idle = 30;
    hold_toggle = ~hold_toggle;
    random_words(RAND_WORDS / 3);

    send_idle = 0;
    recv_idle = 0;
    random_words(RAND_WORDS / 3);

    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
